// File: rtl/core/spb_pkg.sv
// Shared types, codes and the microprogram of the sorted palette builder.
// Used by spb_sequencer, spb_datapath and the top level; depends on nothing.
package spb_pkg;

	// Item kinds as carried on the kind port.
	typedef enum logic [1:0] {
		K_COLLECT = 2'd0,
		K_MAP     = 2'd1,
		K_READ    = 2'd2,
		K_CLEAR   = 2'd3
	} kind_t;

	localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;
	localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PROBE,
		OP_NARROW,
		OP_READ_LO,
		OP_TEST,
		OP_SH_READ,
		OP_SH_WRITE,
		OP_INSERT,
		OP_SET_OVF,
		OP_READ_ENTRY,
		OP_CLEAR,
		OP_FINISH
	} op_t;

	// What a step waits for before it executes.
	typedef enum logic [1:0] {
		W_NONE,
		W_ACCEPT,
		W_OUT
	} wait_t;

	// How the step counter moves on.
	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_DISPATCH,
		J_IF_SEARCH_DONE,
		J_IF_MAP_OR_HIT,
		J_IF_FULL,
		J_IF_SHIFT_DONE
	} jump_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_SRCH    = 4'd1;
	localparam step_t ST_CMP     = 4'd2;
	localparam step_t ST_CHECK   = 4'd3;
	localparam step_t ST_TEST    = 4'd4;
	localparam step_t ST_FULLCHK = 4'd5;
	localparam step_t ST_SH_RD   = 4'd6;
	localparam step_t ST_SH_WR   = 4'd7;
	localparam step_t ST_INS     = 4'd8;
	localparam step_t ST_OVF     = 4'd9;
	localparam step_t ST_RD      = 4'd10;
	localparam step_t ST_CLR     = 4'd11;
	localparam step_t ST_FIN     = 4'd12;

	typedef struct packed {
		wait_t wt;
		op_t   op;
		jump_t jc;
		step_t target;
	} uword_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		op_t  op;
		logic fire;
		logic idle;
	} ctl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic  accept;
		kind_t kind;
		logic  lo_lt_hi;
		logic  map_or_hit;
		logic  full;
		logic  p_gt_lo;
		logic  out_free;
	} stat_t;

	// The microprogram.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{wt: W_NONE, op: OP_NOP, jc: J_ALWAYS, target: ST_IDLE};
		unique case (s)
			ST_IDLE:    w = '{wt: W_ACCEPT, op: OP_LOAD, jc: J_DISPATCH, target: ST_IDLE};
			ST_SRCH:    w = '{wt: W_NONE, op: OP_PROBE, jc: J_IF_SEARCH_DONE,
				target: ST_CHECK};
			ST_CMP:     w = '{wt: W_NONE, op: OP_NARROW, jc: J_ALWAYS, target: ST_SRCH};
			ST_CHECK:   w = '{wt: W_NONE, op: OP_READ_LO, jc: J_NEXT, target: ST_IDLE};
			ST_TEST:    w = '{wt: W_NONE, op: OP_TEST, jc: J_IF_MAP_OR_HIT, target: ST_FIN};
			ST_FULLCHK: w = '{wt: W_NONE, op: OP_NOP, jc: J_IF_FULL, target: ST_OVF};
			ST_SH_RD:   w = '{wt: W_NONE, op: OP_SH_READ, jc: J_IF_SHIFT_DONE,
				target: ST_INS};
			ST_SH_WR:   w = '{wt: W_NONE, op: OP_SH_WRITE, jc: J_ALWAYS, target: ST_SH_RD};
			ST_INS:     w = '{wt: W_NONE, op: OP_INSERT, jc: J_ALWAYS, target: ST_FIN};
			ST_OVF:     w = '{wt: W_NONE, op: OP_SET_OVF, jc: J_ALWAYS, target: ST_FIN};
			ST_RD:      w = '{wt: W_NONE, op: OP_READ_ENTRY, jc: J_ALWAYS, target: ST_FIN};
			ST_CLR:     w = '{wt: W_NONE, op: OP_CLEAR, jc: J_ALWAYS, target: ST_FIN};
			ST_FIN:     w = '{wt: W_OUT, op: OP_FINISH, jc: J_ALWAYS, target: ST_IDLE};
			default:    w = '{wt: W_NONE, op: OP_NOP, jc: J_ALWAYS, target: ST_IDLE};
		endcase
		return w;
	endfunction

	// Entry point of the program for each item kind.
	function automatic step_t dispatch(input kind_t k);
		step_t s;
		unique case (k)
			K_COLLECT: s = ST_SRCH;
			K_MAP:     s = ST_SRCH;
			K_READ:    s = ST_RD;
			K_CLEAR:   s = ST_CLR;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/spb_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on spb_pkg for the microprogram and the control/status structs.
module spb_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  spb_pkg::stat_t stat,
	output spb_pkg::ctl_t  ctl
);
	import spb_pkg::*;

	step_t  step_q;
	step_t  next_step;
	step_t  tgt;
	uword_t uw;
	logic   go;
	logic   take;

	always_comb uw = ucode(step_q);

	always_comb begin
		unique case (uw.wt)
			W_NONE:   go = 1'b1;
			W_ACCEPT: go = stat.accept;
			W_OUT:    go = stat.out_free;
			default:  go = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.jc)
			J_NEXT:           take = 1'b0;
			J_ALWAYS:         take = 1'b1;
			J_DISPATCH:       take = 1'b1;
			J_IF_SEARCH_DONE: take = !stat.lo_lt_hi;
			J_IF_MAP_OR_HIT:  take = stat.map_or_hit;
			J_IF_FULL:        take = stat.full;
			J_IF_SHIFT_DONE:  take = !stat.p_gt_lo;
			default:          take = 1'b1;
		endcase
		tgt = (uw.jc == J_DISPATCH) ? dispatch(stat.kind) : uw.target;
		next_step = take ? tgt : step_t'(step_q + 4'd1);
	end

	always_comb begin
		ctl.op   = uw.op;
		ctl.fire = go;
		ctl.idle = (step_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (go) begin
			step_q <= next_step;
		end
	end

endmodule

// File: rtl/core/spb_datapath.sv
// Datapath: colour table memory, search bounds, shift pointer and result register.
// Depends on spb_pkg; driven by the control word from spb_sequencer.
module spb_datapath #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spb_pkg::ctl_t  ctl,
	input  logic           alpha_mode,
	input  logic           accept,
	input  logic [1:0]     kind,
	input  logic [31:0]    pixel,
	input  logic [7:0]     entry_index,
	input  logic           result_stall,
	output spb_pkg::stat_t stat,
	output logic           result_valid,
	output logic [7:0]     pixel_index,
	output logic [31:0]    entry_colour,
	output logic [8:0]     entry_count,
	output logic           overflow,
	output logic           absent,
	output logic           already_present
);
	import spb_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = (LW > 8) ? LW : 8;

	logic [31:0]   colour_mem_q [TABLE_DEPTH];
	logic [31:0]   rdata_q;
	kind_t         kind_q;
	logic [31:0]   colour_q;
	logic [7:0]    entry_q;
	logic [LW-1:0] lo_q, hi_q, mid_q, p_q, count_q;
	logic          ovf_q, hit_q;
	logic          result_valid_q;
	logic [7:0]    pixel_index_q;
	logic [31:0]   entry_colour_q;
	logic          absent_q, present_q;

	logic [LW-1:0] mid;
	logic [LW-1:0] p_dec;
	logic [EW-1:0] e_ext, cnt_ext;
	logic [LW+7:0] lo_wide;
	logic [LW+8:0] cnt_wide;
	logic          hit_now, out_free, finish;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, masked;

	always_comb begin
		if (alpha_mode) begin
			masked = ((pixel & ALPHA_MASK) == 32'd0) ? 32'd0 : pixel;
		end else begin
			masked = pixel & RGB_MASK;
		end
	end

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign p_dec    = p_q - LW'(1);
	assign e_ext    = EW'(entry_q);
	assign cnt_ext  = EW'(count_q);
	assign lo_wide  = {8'd0, lo_q};
	assign cnt_wide = {9'd0, count_q};
	assign hit_now  = (lo_q < count_q) && (rdata_q == colour_q);
	assign out_free = !result_valid_q || !result_stall;
	assign finish   = ctl.fire && (ctl.op == OP_FINISH);

	always_comb begin
		stat.accept     = accept;
		stat.kind       = kind_t'(kind);
		stat.lo_lt_hi   = lo_q < hi_q;
		stat.map_or_hit = (kind_q == K_MAP) || hit_now;
		stat.full       = count_q >= LW'(TABLE_DEPTH);
		stat.p_gt_lo    = p_q > lo_q;
		stat.out_free   = out_free;
	end

	// One write and one read port, chosen by the current operation.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = p_q[AW-1:0];
		mem_wdata = rdata_q;
		mem_raddr = lo_q[AW-1:0];
		unique case (ctl.op)
			OP_PROBE: begin
				mem_re    = 1'b1;
				mem_raddr = mid[AW-1:0];
			end
			OP_READ_LO: begin
				mem_re = 1'b1;
			end
			OP_SH_READ: begin
				mem_re    = 1'b1;
				mem_raddr = p_dec[AW-1:0];
			end
			OP_READ_ENTRY: begin
				mem_re    = 1'b1;
				mem_raddr = e_ext[AW-1:0];
			end
			OP_SH_WRITE: begin
				mem_we = 1'b1;
			end
			OP_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = colour_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			colour_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= colour_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			unique case (ctl.op)
				OP_LOAD: begin
					kind_q   <= kind_t'(kind);
					colour_q <= masked;
					entry_q  <= entry_index;
					lo_q     <= '0;
					hi_q     <= count_q;
				end
				OP_PROBE:    mid_q <= mid;
				OP_NARROW: begin
					if (rdata_q < colour_q) begin
						lo_q <= mid_q + LW'(1);
					end else begin
						hi_q <= mid_q;
					end
				end
				OP_TEST: begin
					hit_q <= hit_now;
					p_q   <= count_q;
				end
				OP_SH_WRITE: p_q  <= p_dec;
				OP_SET_OVF:  lo_q <= '0;
				OP_FINISH: begin
					unique case (kind_q)
						K_COLLECT: begin
							pixel_index_q  <= lo_wide[7:0];
							entry_colour_q <= 32'd0;
							absent_q       <= 1'b0;
							present_q      <= hit_q;
						end
						K_MAP: begin
							pixel_index_q  <= hit_q ? lo_wide[7:0] : 8'd0;
							entry_colour_q <= 32'd0;
							absent_q       <= !hit_q;
							present_q      <= 1'b0;
						end
						K_READ: begin
							pixel_index_q  <= 8'd0;
							entry_colour_q <= (e_ext < cnt_ext) ? rdata_q : 32'd0;
							absent_q       <= 1'b0;
							present_q      <= 1'b0;
						end
						K_CLEAR: begin
							pixel_index_q  <= 8'd0;
							entry_colour_q <= 32'd0;
							absent_q       <= 1'b0;
							present_q      <= 1'b0;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctl.fire && ctl.op == OP_INSERT) begin
				count_q <= count_q + LW'(1);
			end
			if (ctl.fire && ctl.op == OP_SET_OVF) begin
				ovf_q <= 1'b1;
			end
			if (ctl.fire && ctl.op == OP_CLEAR) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Count and overflow are sampled into the result at the finishing step.
	logic [8:0] count_out_q;
	logic       ovf_out_q;

	always_ff @(posedge clk) begin
		if (finish) begin
			count_out_q <= cnt_wide[8:0];
			ovf_out_q   <= ovf_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign pixel_index     = pixel_index_q;
	assign entry_colour    = entry_colour_q;
	assign entry_count     = count_out_q;
	assign overflow        = ovf_out_q;
	assign absent          = absent_q;
	assign already_present = present_q;

endmodule

// File: rtl/core/sorted_palette_builder_and_mapper.sv
// Top level of the sorted palette builder and mapper.
// Instantiates spb_sequencer and spb_datapath; depends on spb_pkg.
//
// The block keeps up to TABLE_DEPTH distinct colours in ascending order and
// answers one result transaction for every item transaction. Items are worked
// one at a time under a microprogram; item_stall is high from the cycle after
// an item is taken until the program is back at its idle step. A collect or
// map item runs a binary search over the stored colours after its dispatch,
// then a final check and its result. Each probe is a registered read of the
// table memory followed by a compare step. A collect item that inserts a new
// colour also moves every larger entry up one place (read then write on the
// same memory) after a full check, and ends with the last shift test and the
// insert. Read and clear items go from dispatch straight to their own step
// and the result. The result register lets the next item be taken while a
// result still waits; the program then waits at its last step until that
// result has been taken. The table memory has no reset; only entries below
// the count are ever used, so no clearing pass is needed. alpha_mode is
// written through the configuration channel, which is ready while the block
// is idle.
module sorted_palette_builder_and_mapper #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_alpha_mode,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] pixel,
	input  logic [7:0]  entry_index,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  pixel_index,
	output logic [31:0] entry_colour,
	output logic [8:0]  entry_count,
	output logic        overflow,
	output logic        absent,
	output logic        already_present
);
	import spb_pkg::*;

	ctl_t  ctl;
	stat_t stat;
	logic  alpha_mode_q;
	logic  item_accept;

	// Items are taken only at the idle step of the program.
	assign item_stall  = !ctl.idle;
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = ctl.idle;

	// The mode register applies to pixels masked from the next item on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			alpha_mode_q <= cfg_alpha_mode;
		end
	end

	spb_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	spb_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.alpha_mode      (alpha_mode_q),
		.accept          (item_accept),
		.kind            (kind),
		.pixel           (pixel),
		.entry_index     (entry_index),
		.result_stall    (result_stall),
		.stat            (stat),
		.result_valid    (result_valid),
		.pixel_index     (pixel_index),
		.entry_colour    (entry_colour),
		.entry_count     (entry_count),
		.overflow        (overflow),
		.absent          (absent),
		.already_present (already_present)
	);

`ifndef SYNTH
	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |=> item_stall)
		else $error("item taken while the previous one was still in work");

	// A colour that was not found never reports a table position.
	a_absent_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && absent |-> pixel_index == 8'd0)
		else $error("absent result carries a nonzero index");

	// Present and absent belong to different item kinds.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(absent && already_present))
		else $error("absent and already_present both set");

	// A read result never carries a table position.
	a_read_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && entry_colour != 32'd0 |-> pixel_index == 8'd0)
		else $error("read result carries a nonzero index");
`endif

endmodule
